FILE: rtl/rgb2yuv_pkg.sv
// Shared constants, types and helpers for the RGB to YUV420 converter.
package rgb2yuv_pkg;

    localparam int DEFAULT_MAX_WIDTH  = 4096;
    localparam int DEFAULT_MAX_HEIGHT = 4096;

    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;
    localparam int MIN_SIZE     = 2;

    localparam int CFG_DATA_W  = 13;
    localparam int CFG_INDEX_W = 1;
    localparam int PIX_W       = 8;
    localparam int LUMA_ADDR_W = 24;
    localparam int CHROMA_ADDR_W = 25;

    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    localparam int COEF_W    = 12;
    localparam int FRAC_BITS = 12;

    localparam logic [COEF_W-1:0] K_Y_R = 12'd1224;
    localparam logic [COEF_W-1:0] K_Y_G = 12'd2404;
    localparam logic [COEF_W-1:0] K_Y_B = 12'd469;
    localparam logic [COEF_W-1:0] K_U_R = 12'd692;
    localparam logic [COEF_W-1:0] K_U_G = 12'd1356;
    localparam logic [COEF_W-1:0] K_V_G = 12'd1731;
    localparam logic [COEF_W-1:0] K_V_B = 12'd334;

    localparam int CHROMA_OFFSET = 128;

    typedef struct packed {
        logic [CHROMA_ADDR_W-1:0] cb_base;
        logic [CHROMA_ADDR_W-1:0] cr_base;
    } plane_base_t;

    function automatic logic [PIX_W-1:0] fx_mul(input logic [PIX_W-1:0] x,
                                                input logic [COEF_W-1:0] k);
        logic [PIX_W+COEF_W-1:0] prod;
        prod = (PIX_W+COEF_W)'(x) * (PIX_W+COEF_W)'(k);
        return prod[PIX_W+COEF_W-1:FRAC_BITS];
    endfunction

endpackage

FILE: rtl/rgb2yuv_cfg.sv
// Frame size registers with clamping and chroma plane base addresses.
module rgb2yuv_cfg #(
    parameter int MAX_WIDTH  = rgb2yuv_pkg::DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = rgb2yuv_pkg::DEFAULT_MAX_HEIGHT,
    parameter int WW = $clog2(MAX_WIDTH + 1),
    parameter int HW = $clog2(MAX_HEIGHT + 1)
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [rgb2yuv_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [rgb2yuv_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic [WW-1:0]                         width,
    output logic [HW-1:0]                         height,
    output rgb2yuv_pkg::plane_base_t              plane_base
);

    localparam int RST_W = (rgb2yuv_pkg::RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH
                                                                  : rgb2yuv_pkg::RESET_WIDTH;
    localparam int RST_H = (rgb2yuv_pkg::RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT
                                                                    : rgb2yuv_pkg::RESET_HEIGHT;
    localparam int SZW = WW + HW;

    logic [WW-1:0] width_reg, width_next, width_clamp;
    logic [HW-1:0] height_reg, height_next, height_clamp;
    rgb2yuv_pkg::plane_base_t base_reg, base_next;
    logic [SZW-1:0] pixel_total;
    logic [SZW:0]   cr_offset;

    always_comb
    begin
        if (32'(cfg_data) < rgb2yuv_pkg::MIN_SIZE)
            width_clamp = WW'(rgb2yuv_pkg::MIN_SIZE);
        else if (32'(cfg_data) > MAX_WIDTH)
            width_clamp = WW'(MAX_WIDTH);
        else
            width_clamp = WW'(cfg_data);

        if (32'(cfg_data) < rgb2yuv_pkg::MIN_SIZE)
            height_clamp = HW'(rgb2yuv_pkg::MIN_SIZE);
        else if (32'(cfg_data) > MAX_HEIGHT)
            height_clamp = HW'(MAX_HEIGHT);
        else
            height_clamp = HW'(cfg_data);
    end

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                rgb2yuv_pkg::CFG_FRAME_WIDTH:  width_next  = width_clamp;
                rgb2yuv_pkg::CFG_FRAME_HEIGHT: height_next = height_clamp;
                default: ;
            endcase
        end
    end

    // chroma planes sit at one and five quarters of the frame size
    always_comb
    begin
        pixel_total = SZW'(width_reg) * SZW'(height_reg);
        cr_offset   = (SZW+1)'(pixel_total) + (SZW+1)'(pixel_total >> 2);
        base_next.cb_base = rgb2yuv_pkg::CHROMA_ADDR_W'(pixel_total);
        base_next.cr_base = rgb2yuv_pkg::CHROMA_ADDR_W'(cr_offset);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WW'(RST_W);
            height_reg <= HW'(RST_H);
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg <= base_next;
    end

    assign width      = width_reg;
    assign height     = height_reg;
    assign plane_base = base_reg;

endmodule

FILE: rtl/rgb2yuv_scan.sv
// Raster position counters: column, row and linear pixel index.
module rgb2yuv_scan #(
    parameter int MAX_WIDTH  = rgb2yuv_pkg::DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = rgb2yuv_pkg::DEFAULT_MAX_HEIGHT,
    parameter int WW = $clog2(MAX_WIDTH + 1),
    parameter int HW = $clog2(MAX_HEIGHT + 1),
    parameter int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
    parameter int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  advance,
    input  logic [WW-1:0]                         width,
    input  logic [HW-1:0]                         height,
    output logic [CW-1:0]                         column,
    output logic [RW-1:0]                         row,
    output logic [rgb2yuv_pkg::LUMA_ADDR_W-1:0]   pixel_index,
    output logic                                  chroma_site,
    output logic                                  frame_end
);

    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [rgb2yuv_pkg::LUMA_ADDR_W-1:0] pix_reg, pix_next;
    logic line_end;

    always_comb
    begin
        line_end    = WW'(col_reg) >= (width - WW'(1));
        frame_end   = line_end && (HW'(row_reg) >= (height - HW'(1)));
        chroma_site = col_reg[0] && row_reg[0];

        col_next = col_reg;
        row_next = row_reg;
        pix_next = pix_reg;
        if (advance)
        begin
            if (frame_end)
            begin
                col_next = '0;
                row_next = '0;
                pix_next = '0;
            end
            else
            begin
                if (line_end)
                begin
                    col_next = '0;
                    row_next = row_reg + RW'(1);
                end
                else
                begin
                    col_next = col_reg + CW'(1);
                end
                pix_next = pix_reg + rgb2yuv_pkg::LUMA_ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            pix_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            pix_reg <= pix_next;
        end
    end

    assign column      = col_reg;
    assign row         = row_reg;
    assign pixel_index = pix_reg;

endmodule

FILE: rtl/rgb2yuv_calc.sv
// Color conversion and chroma plane address arithmetic for one pixel.
module rgb2yuv_calc #(
    parameter int MAX_WIDTH  = rgb2yuv_pkg::DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = rgb2yuv_pkg::DEFAULT_MAX_HEIGHT,
    parameter int WW = $clog2(MAX_WIDTH + 1),
    parameter int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
    parameter int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
    input  logic [rgb2yuv_pkg::PIX_W-1:0]         red,
    input  logic [rgb2yuv_pkg::PIX_W-1:0]         green,
    input  logic [rgb2yuv_pkg::PIX_W-1:0]         blue,
    input  logic [CW-1:0]                         column,
    input  logic [RW-1:0]                         row,
    input  logic                                  chroma_site,
    input  logic [WW-1:0]                         width,
    input  rgb2yuv_pkg::plane_base_t              plane_base,
    output logic [rgb2yuv_pkg::PIX_W-1:0]         luma,
    output logic [rgb2yuv_pkg::PIX_W-1:0]         cb_value,
    output logic [rgb2yuv_pkg::CHROMA_ADDR_W-1:0] cb_addr,
    output logic [rgb2yuv_pkg::PIX_W-1:0]         cr_value,
    output logic [rgb2yuv_pkg::CHROMA_ADDR_W-1:0] cr_addr
);

    localparam int PW  = rgb2yuv_pkg::PIX_W;
    localparam int SW  = PW + 2;
    localparam int OW  = WW + RW + 1;
    localparam int AW  = rgb2yuv_pkg::CHROMA_ADDR_W;

    logic [SW-1:0] y_sum, u_sum, v_sum;
    logic [OW-1:0] sub_offset;

    always_comb
    begin
        y_sum = SW'(rgb2yuv_pkg::fx_mul(red,   rgb2yuv_pkg::K_Y_R))
              + SW'(rgb2yuv_pkg::fx_mul(green, rgb2yuv_pkg::K_Y_G))
              + SW'(rgb2yuv_pkg::fx_mul(blue,  rgb2yuv_pkg::K_Y_B));

        u_sum = SW'(blue >> 1) + SW'(rgb2yuv_pkg::CHROMA_OFFSET)
              - SW'(rgb2yuv_pkg::fx_mul(red,   rgb2yuv_pkg::K_U_R))
              - SW'(rgb2yuv_pkg::fx_mul(green, rgb2yuv_pkg::K_U_G));

        v_sum = SW'(red >> 1) + SW'(rgb2yuv_pkg::CHROMA_OFFSET)
              - SW'(rgb2yuv_pkg::fx_mul(green, rgb2yuv_pkg::K_V_G))
              - SW'(rgb2yuv_pkg::fx_mul(blue,  rgb2yuv_pkg::K_V_B));

        sub_offset = OW'(width >> 1) * OW'(row >> 1) + OW'(column >> 1);

        luma = y_sum[PW-1:0];
        if (chroma_site)
        begin
            cb_value = u_sum[PW-1:0];
            cr_value = v_sum[PW-1:0];
            cb_addr  = plane_base.cb_base + AW'(sub_offset);
            cr_addr  = plane_base.cr_base + AW'(sub_offset);
        end
        else
        begin
            cb_value = '0;
            cr_value = '0;
            cb_addr  = '0;
            cr_addr  = '0;
        end
    end

endmodule

FILE: rtl/rgb_to_yuv420_converter_core.sv
// Top level of the RGB to planar YUV420 converter.
// Takes one RGB pixel per cycle in raster order while in_ready is high and returns one word
// per pixel: its luma, the luma address, and at odd columns of odd rows the decimated U and
// V with their plane addresses; frame_last marks the last pixel of a frame. Throughput is
// one pixel per clock unless out_ready stalls; each pixel passes the input register (with
// its raster position) and the result register. Frame size writes clamp to 2..MAX_WIDTH
// and 2..MAX_HEIGHT and take effect for pixels accepted in the cycle after the write.
module rgb_to_yuv420_converter_core #(
    parameter int MAX_WIDTH  = rgb2yuv_pkg::DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = rgb2yuv_pkg::DEFAULT_MAX_HEIGHT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [rgb2yuv_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [rgb2yuv_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [rgb2yuv_pkg::PIX_W-1:0]         red,
    input  logic [rgb2yuv_pkg::PIX_W-1:0]         green,
    input  logic [rgb2yuv_pkg::PIX_W-1:0]         blue,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [rgb2yuv_pkg::PIX_W-1:0]         luma,
    output logic [rgb2yuv_pkg::LUMA_ADDR_W-1:0]   luma_addr,
    output logic                                  chroma_valid,
    output logic [rgb2yuv_pkg::PIX_W-1:0]         cb_value,
    output logic [rgb2yuv_pkg::CHROMA_ADDR_W-1:0] cb_addr,
    output logic [rgb2yuv_pkg::PIX_W-1:0]         cr_value,
    output logic [rgb2yuv_pkg::CHROMA_ADDR_W-1:0] cr_addr,
    output logic                                  frame_last
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int PW = rgb2yuv_pkg::PIX_W;
    localparam int LW = rgb2yuv_pkg::LUMA_ADDR_W;
    localparam int AW = rgb2yuv_pkg::CHROMA_ADDR_W;

    logic [WW-1:0] width;
    logic [HW-1:0] height;
    rgb2yuv_pkg::plane_base_t plane_base;

    logic          accept;
    logic          res_ready;
    logic [CW-1:0] cur_col;
    logic [RW-1:0] cur_row;
    logic [LW-1:0] cur_pix;
    logic          cur_site;
    logic          cur_end;

    // input stage
    logic          s1_valid_reg, s1_valid_next;
    logic [PW-1:0] s1_red_reg, s1_green_reg, s1_blue_reg;
    logic [CW-1:0] s1_col_reg;
    logic [RW-1:0] s1_row_reg;
    logic [LW-1:0] s1_pix_reg;
    logic          s1_site_reg;
    logic          s1_end_reg;

    // result stage
    logic          out_valid_reg, out_valid_next;
    logic [PW-1:0] luma_reg, luma_next;
    logic [LW-1:0] luma_addr_reg;
    logic          chroma_valid_reg;
    logic [PW-1:0] cb_value_reg, cb_value_next;
    logic [AW-1:0] cb_addr_reg, cb_addr_next;
    logic [PW-1:0] cr_value_reg, cr_value_next;
    logic [AW-1:0] cr_addr_reg, cr_addr_next;
    logic          frame_last_reg;

    rgb2yuv_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .WW         (WW),
        .HW         (HW)
    ) u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .width      (width),
        .height     (height),
        .plane_base (plane_base)
    );

    rgb2yuv_scan #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .WW          (WW),
        .HW          (HW),
        .CW          (CW),
        .RW          (RW)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (accept),
        .width       (width),
        .height      (height),
        .column      (cur_col),
        .row         (cur_row),
        .pixel_index (cur_pix),
        .chroma_site (cur_site),
        .frame_end   (cur_end)
    );

    rgb2yuv_calc #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .WW          (WW),
        .CW          (CW),
        .RW          (RW)
    ) u_calc (
        .red         (s1_red_reg),
        .green       (s1_green_reg),
        .blue        (s1_blue_reg),
        .column      (s1_col_reg),
        .row         (s1_row_reg),
        .chroma_site (s1_site_reg),
        .width       (width),
        .plane_base  (plane_base),
        .luma        (luma_next),
        .cb_value    (cb_value_next),
        .cb_addr     (cb_addr_next),
        .cr_value    (cr_value_next),
        .cr_addr     (cr_addr_next)
    );

    assign res_ready = !out_valid_reg || out_ready;
    assign in_ready  = !s1_valid_reg || res_ready;
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (in_ready)
            s1_valid_next = in_valid;
        if (res_ready)
            out_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // capture the pixel with its raster position
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_red_reg   <= red;
            s1_green_reg <= green;
            s1_blue_reg  <= blue;
            s1_col_reg   <= cur_col;
            s1_row_reg   <= cur_row;
            s1_pix_reg   <= cur_pix;
            s1_site_reg  <= cur_site;
            s1_end_reg   <= cur_end;
        end
    end

    // advance the result word when the output side can take it
    always_ff @(posedge clk)
    begin
        if (res_ready && s1_valid_reg)
        begin
            luma_reg         <= luma_next;
            luma_addr_reg    <= s1_pix_reg;
            chroma_valid_reg <= s1_site_reg;
            cb_value_reg     <= cb_value_next;
            cb_addr_reg      <= cb_addr_next;
            cr_value_reg     <= cr_value_next;
            cr_addr_reg      <= cr_addr_next;
            frame_last_reg   <= s1_end_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign luma         = luma_reg;
    assign luma_addr    = luma_addr_reg;
    assign chroma_valid = chroma_valid_reg;
    assign cb_value     = cb_value_reg;
    assign cb_addr      = cb_addr_reg;
    assign cr_value     = cr_value_reg;
    assign cr_addr      = cr_addr_reg;
    assign frame_last   = frame_last_reg;

endmodule

FILE: rtl/rgb2yuv_checker.sv
// Port-level assertions for the RGB to YUV420 converter, bound to the top level.
module rgb2yuv_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  in_ready,
    input logic                                  out_valid,
    input logic                                  out_ready,
    input logic [rgb2yuv_pkg::LUMA_ADDR_W-1:0]   luma_addr,
    input logic                                  chroma_valid,
    input logic [rgb2yuv_pkg::PIX_W-1:0]         cb_value,
    input logic [rgb2yuv_pkg::CHROMA_ADDR_W-1:0] cb_addr,
    input logic [rgb2yuv_pkg::PIX_W-1:0]         cr_value,
    input logic [rgb2yuv_pkg::CHROMA_ADDR_W-1:0] cr_addr
);

    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("output word valid during reset");

    a_empty_takes_input: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    a_no_chroma_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !chroma_valid |->
            cb_value == '0 && cr_value == '0 && cb_addr == '0 && cr_addr == '0)
        else $error("chroma fields set on a non-chroma word");

    a_planes_apart: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && chroma_valid |-> cb_addr != cr_addr)
        else $error("U and V addresses collide");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(luma_addr) && $stable(cb_addr))
        else $error("stalled word changed");

endmodule

bind rgb_to_yuv420_converter_core rgb2yuv_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .luma_addr    (luma_addr),
    .chroma_valid (chroma_valid),
    .cb_value     (cb_value),
    .cb_addr      (cb_addr),
    .cr_value     (cr_value),
    .cr_addr      (cr_addr)
);

FILE: verif/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the RGB to YUV420 converter core: scoreboard with a pixel predictor and stream drivers.

typedef struct packed {
    logic [rgb2yuv_pkg::PIX_W-1:0]         luma;
    logic [rgb2yuv_pkg::LUMA_ADDR_W-1:0]   luma_addr;
    logic                                  chroma_valid;
    logic [rgb2yuv_pkg::PIX_W-1:0]         cb_value;
    logic [rgb2yuv_pkg::CHROMA_ADDR_W-1:0] cb_addr;
    logic [rgb2yuv_pkg::PIX_W-1:0]         cr_value;
    logic [rgb2yuv_pkg::CHROMA_ADDR_W-1:0] cr_addr;
    logic                                  frame_last;
} yuv_word_t;

class yuv_scoreboard;
    logic [rgb2yuv_pkg::CFG_DATA_W-1:0]  width_reg;
    logic [rgb2yuv_pkg::CFG_DATA_W-1:0]  height_reg;
    int                                  column;
    int                                  row;
    logic [rgb2yuv_pkg::LUMA_ADDR_W-1:0] pixel_addr;
    yuv_word_t                           pending_q[$];
    int                                  errors;

    function new();
        width_reg  = rgb2yuv_pkg::CFG_DATA_W'(rgb2yuv_pkg::RESET_WIDTH);
        height_reg = rgb2yuv_pkg::CFG_DATA_W'(rgb2yuv_pkg::RESET_HEIGHT);
        column     = 0;
        row        = 0;
        pixel_addr = '0;
        errors     = 0;
    endfunction

    function void write_reg(logic [rgb2yuv_pkg::CFG_INDEX_W-1:0] index,
                            logic [rgb2yuv_pkg::CFG_DATA_W-1:0] data);
        if (index == rgb2yuv_pkg::CFG_FRAME_WIDTH)
            width_reg = data;
        else if (index == rgb2yuv_pkg::CFG_FRAME_HEIGHT)
            height_reg = data;
    endfunction

    static function int scaled(int x, int k);
        return (x * k) >> rgb2yuv_pkg::FRAC_BITS;
    endfunction

    static function int clamp_size(int v, int hi);
        if (v < rgb2yuv_pkg::MIN_SIZE)
            return rgb2yuv_pkg::MIN_SIZE;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function void note_pixel(int r, int g, int b);
        int        w;
        int        h;
        int        plane_size;
        int        sub_offset;
        bit        line_end;
        yuv_word_t want;
        w = clamp_size(int'(width_reg), rgb2yuv_pkg::DEFAULT_MAX_WIDTH);
        h = clamp_size(int'(height_reg), rgb2yuv_pkg::DEFAULT_MAX_HEIGHT);
        want = '0;
        want.luma = 8'(scaled(r, rgb2yuv_pkg::K_Y_R) + scaled(g, rgb2yuv_pkg::K_Y_G)
                       + scaled(b, rgb2yuv_pkg::K_Y_B));
        want.luma_addr = pixel_addr;
        want.chroma_valid = (column % 2 == 1) && (row % 2 == 1);
        if (want.chroma_valid)
        begin
            plane_size = w * h;
            sub_offset = (w >> 1) * (row >> 1) + (column >> 1);
            want.cb_value = 8'((b >> 1) + rgb2yuv_pkg::CHROMA_OFFSET
                               - scaled(r, rgb2yuv_pkg::K_U_R) - scaled(g, rgb2yuv_pkg::K_U_G));
            want.cr_value = 8'((r >> 1) + rgb2yuv_pkg::CHROMA_OFFSET
                               - scaled(g, rgb2yuv_pkg::K_V_G) - scaled(b, rgb2yuv_pkg::K_V_B));
            want.cb_addr = 25'(plane_size + sub_offset);
            want.cr_addr = 25'((5 * plane_size) / 4 + sub_offset);
        end
        line_end = column >= w - 1;
        want.frame_last = line_end && (row >= h - 1);
        pending_q.push_back(want);
        if (want.frame_last)
        begin
            column     = 0;
            row        = 0;
            pixel_addr = '0;
        end
        else
        begin
            if (line_end)
            begin
                column = 0;
                row    = row + 1;
            end
            else
                column = column + 1;
            pixel_addr = pixel_addr + 1'b1;
        end
    endfunction

    function void check_word(yuv_word_t got);
        yuv_word_t want;
        if (pending_q.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("%0t: unexpected word, luma %0d addr %0d", $time, got.luma,
                         got.luma_addr);
            return;
        end
        want = pending_q.pop_front();
        if (got.luma !== want.luma || got.luma_addr !== want.luma_addr
            || got.chroma_valid !== want.chroma_valid || got.cb_value !== want.cb_value
            || got.cb_addr !== want.cb_addr || got.cr_value !== want.cr_value
            || got.cr_addr !== want.cr_addr || got.frame_last !== want.frame_last)
        begin
            errors++;
            if (errors <= 10)
                $display({"%0t: mismatch exp/act luma %0d/%0d addr %0d/%0d cvalid %0d/%0d",
                          " cb %0d@%0d/%0d@%0d cr %0d@%0d/%0d@%0d last %0d/%0d"},
                         $time, want.luma, got.luma, want.luma_addr, got.luma_addr,
                         want.chroma_valid, got.chroma_valid, want.cb_value, want.cb_addr,
                         got.cb_value, got.cb_addr, want.cr_value, want.cr_addr,
                         got.cr_value, got.cr_addr, want.frame_last, got.frame_last);
        end
    endfunction
endclass

module tb;
    localparam int LONG_STALL = 120;

    logic                                  clk = 1'b0;
    logic                                  rst_n = 1'b0;
    logic                                  cfg_wr_en = 1'b0;
    logic [rgb2yuv_pkg::CFG_INDEX_W-1:0]   cfg_index = rgb2yuv_pkg::CFG_FRAME_WIDTH;
    logic [rgb2yuv_pkg::CFG_DATA_W-1:0]    cfg_data = '0;
    logic                                  in_valid = 1'b0;
    logic                                  in_ready;
    logic [rgb2yuv_pkg::PIX_W-1:0]         red = '0;
    logic [rgb2yuv_pkg::PIX_W-1:0]         green = '0;
    logic [rgb2yuv_pkg::PIX_W-1:0]         blue = '0;
    logic                                  out_valid;
    logic                                  out_ready = 1'b0;
    logic [rgb2yuv_pkg::PIX_W-1:0]         luma;
    logic [rgb2yuv_pkg::LUMA_ADDR_W-1:0]   luma_addr;
    logic                                  chroma_valid;
    logic [rgb2yuv_pkg::PIX_W-1:0]         cb_value;
    logic [rgb2yuv_pkg::CHROMA_ADDR_W-1:0] cb_addr;
    logic [rgb2yuv_pkg::PIX_W-1:0]         cr_value;
    logic [rgb2yuv_pkg::CHROMA_ADDR_W-1:0] cr_addr;
    logic                                  frame_last;

    bit            bursts_on = 1'b0;
    bit            stall_request = 1'b0;
    yuv_scoreboard sb = new();
    logic [23:0]   corner_colors[6] = '{24'h000000, 24'hFFFFFF, 24'hFF0000,
                                        24'h00FF00, 24'h0000FF, 24'h01FE80};

    rgb_to_yuv420_converter_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .luma         (luma),
        .luma_addr    (luma_addr),
        .chroma_valid (chroma_valid),
        .cb_value     (cb_value),
        .cb_addr      (cb_addr),
        .cr_value     (cr_value),
        .cr_addr      (cr_addr),
        .frame_last   (frame_last)
    );

    always #5 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (!rst_n)
                out_ready <= 1'b0;
            else if (stall_request)
            begin
                stall_request = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_STALL - 1) @(negedge clk);
            end
            else if (bursts_on && $urandom_range(0, 99) < 15)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(0, 13)) @(negedge clk);
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_word('{luma, luma_addr, chroma_valid, cb_value, cb_addr, cr_value,
                            cr_addr, frame_last});
    end

    task automatic push_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        @(negedge clk);
        in_valid <= 1'b1;
        red      <= r;
        green    <= g;
        blue     <= b;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_pixel(r, g, b);
    endtask

    task automatic push_random();
        push_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)));
    endtask

    task automatic pause_sender(int cycles);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_size(int w, int h);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= rgb2yuv_pkg::CFG_FRAME_WIDTH;
        cfg_data  <= 13'(w);
        @(posedge clk);
        sb.write_reg(rgb2yuv_pkg::CFG_FRAME_WIDTH, 13'(w));
        @(negedge clk);
        cfg_index <= rgb2yuv_pkg::CFG_FRAME_HEIGHT;
        cfg_data  <= 13'(h);
        @(posedge clk);
        sb.write_reg(rgb2yuv_pkg::CFG_FRAME_HEIGHT, 13'(h));
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        repeat (2) @(posedge clk);
    endtask

    task automatic run_phase(int w, int h, int count, bit idle, bit pause_mid,
                             bit long_stall);
        drain_results();
        write_size(w, h);
        bursts_on = idle;
        if (long_stall)
            stall_request = 1'b1;
        for (int i = 0; i < count; i++)
        begin
            if (pause_mid && i == count / 2)
                drain_results();
            if (bursts_on && $urandom_range(0, 99) < 20)
                pause_sender($urandom_range(1, 14));
            push_random();
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // hold the reset size for a few pixels, then shrink it mid-line
        repeat (3) push_random();
        drain_results();
        write_size(2, 2);
        foreach (corner_colors[c])
            repeat (4) push_pixel(corner_colors[c][23:16], corner_colors[c][15:8],
                                  corner_colors[c][7:0]);

        run_phase(3, 3, 150, 1'b1, 1'b0, 1'b0);
        run_phase(4, 2, 150, 1'b1, 1'b1, 1'b0);
        run_phase(1, 0, 100, 1'b1, 1'b0, 1'b0);
        run_phase(7, 5, 150, 1'b0, 1'b0, 1'b0);
        run_phase(16, 9, 150, 1'b1, 1'b0, 1'b0);
        run_phase(8191, 8191, 40, 1'b1, 1'b0, 1'b0);
        run_phase(2, 4096, 150, 1'b1, 1'b0, 1'b0);
        run_phase(4097, 3, 30, 1'b1, 1'b0, 1'b0);
        run_phase(12, 12, 200, 1'b1, 1'b0, 1'b1);
        run_phase($urandom_range(2, 40), $urandom_range(2, 40), 250, 1'b1, 1'b0, 1'b0);
        run_phase(10, 6, 230, 1'b0, 1'b0, 1'b0);
        drain_results();

        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

FILE: files.f
rtl/rgb2yuv_pkg.sv
rtl/rgb2yuv_cfg.sv
rtl/rgb2yuv_scan.sv
rtl/rgb2yuv_calc.sv
rtl/rgb_to_yuv420_converter_core.sv
rtl/rgb2yuv_checker.sv
verif/tb.sv
